// ===== hdl/tpds_pkg.sv =====
// Shared types and constants for the twin prime difference set membership test.
// Used by tpds_jacobi and twin_prime_difference_set_member_top; no dependencies.
`timescale 1ns / 1ps

package tpds_pkg;

  // Width of coordinates and of the configured prime
  localparam int unsigned VALUE_W = 32;
  // Modulus width: q = p + 2 needs one extra bit
  localparam int unsigned MOD_W   = VALUE_W + 1;

  // Reset value of the configured prime
  localparam logic [VALUE_W-1:0] FIRST_PRIME_RST = VALUE_W'(3);

  // One input item
  typedef struct packed {
    logic [VALUE_W-1:0] coord_a;
    logic [VALUE_W-1:0] coord_b;
  } in_t;

  // One result item
  typedef struct packed {
    logic is_member;
    logic a_is_residue;
    logic b_is_residue;
    logic out_of_range;
  } out_t;

  // Request into the Jacobi unit
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] x;
    logic [MOD_W-1:0] n;
  } jac_req_t;

  // Response from the Jacobi unit
  typedef struct packed {
    logic done;
    logic is_one;
  } jac_rsp_t;

endpackage

// ===== hdl/tpds_jacobi.sv =====
// Iterative binary Jacobi symbol unit: one halve or subtract step per cycle.
// Depends on tpds_pkg for widths and the request / response structs.
`timescale 1ns / 1ps

module tpds_jacobi (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tpds_pkg::jac_req_t req_i,
  output tpds_pkg::jac_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    J_IDLE = 2'b01,
    J_RUN  = 2'b10
  } jac_state_e;

  jac_state_e state_q, state_d;
  logic [tpds_pkg::MOD_W-1:0] x_q, x_d;
  logic [tpds_pkg::MOD_W-1:0] n_q, n_d;
  logic                       neg_q, neg_d;

  logic                       x_lt_n;
  logic [tpds_pkg::MOD_W-1:0] sub_a, sub_b, diff;

  // Shared subtractor: always larger minus smaller
  assign x_lt_n = (x_q < n_q);
  assign sub_a  = x_lt_n ? n_q : x_q;
  assign sub_b  = x_lt_n ? x_q : n_q;
  assign diff   = sub_a - sub_b;

  // Step the symbol: halve x, subtract, or swap with reciprocity
  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    n_d          = n_q;
    neg_d        = neg_q;
    rsp_o.done   = 1'b0;
    rsp_o.is_one = 1'b0;
    unique case (state_q)
      J_IDLE: begin
        if (req_i.start) begin
          state_d = J_RUN;
          x_d     = req_i.x;
          n_d     = req_i.n;
          neg_d   = 1'b0;
        end
      end
      J_RUN: begin
        priority if (!n_q[0]) begin
          // even or zero modulus: symbol is zero
          rsp_o.done = 1'b1;
          state_d    = J_IDLE;
        end else if (x_q == '0) begin
          rsp_o.done   = 1'b1;
          rsp_o.is_one = (n_q == tpds_pkg::MOD_W'(1)) && !neg_q;
          state_d      = J_IDLE;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
          if (n_q[2:0] == 3'd3 || n_q[2:0] == 3'd5) begin
            neg_d = !neg_q;
          end
        end else if (!x_lt_n) begin
          x_d = diff;
        end else begin
          // swap: (x/n) -> (n-x / x), flip when both are 3 mod 4
          x_d = diff;
          n_d = x_q;
          if (x_q[1:0] == 2'd3 && n_q[1:0] == 2'd3) begin
            neg_d = !neg_q;
          end
        end
        // A start that arrives with done chains the next evaluation
        if (rsp_o.done && req_i.start) begin
          state_d = J_RUN;
          x_d     = req_i.x;
          n_d     = req_i.n;
          neg_d   = 1'b0;
        end
      end
      default: state_d = J_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= J_IDLE;
      neg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
    end
  end

  // Hold operands
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    n_q <= n_d;
  end

`ifndef SYNTH
  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> (state_q == J_IDLE) || rsp_o.done)
    else $error("jacobi unit started while busy");

  a_mod_stays_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == J_RUN) && n_q[0] && !rsp_o.done |=> n_q[0])
    else $error("odd modulus became even during evaluation");

  a_even_mod_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == J_RUN) && !n_q[0] |-> rsp_o.done && !rsp_o.is_one)
    else $error("even modulus did not give a zero symbol");
`endif

endmodule

// ===== hdl/twin_prime_difference_set_member_top.sv =====
// Top level of the twin prime difference set membership test.
// Depends on tpds_pkg and tpds_jacobi.
`timescale 1ns / 1ps

// Usage
//   Write the prime p through cfg_we_i / cfg_wdata_i while the block is idle;
//   q = p + 2 is formed inside. Reset sets p to 3.
//   Issue an item by raising start with item_i; it is taken at a clock edge
//   where busy is low. busy stays high until the item is finished.
//   The result appears on result_o for exactly one cycle with result_valid_o.
//   The receiver cannot stall; a result must be taken in its strobe cycle.
// Flow
//   An out-of-range pair gives its result in the cycle after acceptance and
//   busy stays low, so a new item may follow every cycle.
//   An in-range pair runs two Jacobi evaluations, a mod p then b mod q,
//   through one shared unit doing one halve or compare-and-subtract per
//   cycle, plus a closing step. Each halve drops a bit from x and each
//   subtract is followed by a halve or by the end. The result shows in the
//   cycle after the second ends. A new item can be accepted in the cycle
//   its result shows.
// Reset
//   rst_ni is asynchronous and active low; it drops any item in flight.

module twin_prime_difference_set_member_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  tpds_pkg::in_t  item_i,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_wdata_i,
  output logic           result_valid_o,
  output tpds_pkg::out_t result_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_JAC_A = 3'b010,
    S_JAC_B = 3'b100
  } seq_state_e;

  seq_state_e state_q, state_d;

  logic [tpds_pkg::VALUE_W-1:0] first_prime_q;
  logic [tpds_pkg::VALUE_W-1:0] b_q;
  logic [tpds_pkg::MOD_W-1:0]   q_mod_q;
  logic                         a_zero_q, b_zero_q, a_res_q;
  logic                         a_res_d;
  logic                         valid_q, valid_d;
  tpds_pkg::out_t               result_q, result_d;

  tpds_pkg::jac_req_t           jac_req;
  tpds_pkg::jac_rsp_t           jac_rsp;

  logic                         accept;
  logic [tpds_pkg::MOD_W-1:0]   q_mod;
  logic                         oor;
  logic                         b_res;

  // Shared Jacobi unit
  tpds_jacobi u_jacobi (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (jac_req),
    .rsp_o  (jac_rsp)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign q_mod  = {1'b0, first_prime_q} + tpds_pkg::MOD_W'(2);
  assign oor    = (item_i.coord_a >= first_prime_q) ||
                  ({1'b0, item_i.coord_b} >= q_mod);
  assign b_res  = jac_rsp.is_one && !b_zero_q;

  // Sequence: range check, then a mod p, then b mod q
  always_comb begin
    state_d       = state_q;
    a_res_d       = a_res_q;
    valid_d       = 1'b0;
    result_d      = result_q;
    jac_req.start = 1'b0;
    jac_req.x     = {1'b0, item_i.coord_a};
    jac_req.n     = {1'b0, first_prime_q};
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (oor) begin
            valid_d               = 1'b1;
            result_d.is_member    = 1'b0;
            result_d.a_is_residue = 1'b0;
            result_d.b_is_residue = 1'b0;
            result_d.out_of_range = 1'b1;
          end else begin
            jac_req.start = 1'b1;
            state_d       = S_JAC_A;
          end
        end
      end
      S_JAC_A: begin
        jac_req.x = {1'b0, b_q};
        jac_req.n = q_mod_q;
        if (jac_rsp.done) begin
          a_res_d       = jac_rsp.is_one && !a_zero_q;
          jac_req.start = 1'b1;
          state_d       = S_JAC_B;
        end
      end
      S_JAC_B: begin
        if (jac_rsp.done) begin
          valid_d               = 1'b1;
          result_d.a_is_residue = a_res_q;
          result_d.b_is_residue = b_res;
          result_d.out_of_range = 1'b0;
          priority if (b_zero_q) begin
            result_d.is_member = 1'b1;
          end else if (a_zero_q) begin
            result_d.is_member = 1'b0;
          end else begin
            result_d.is_member = (a_res_q == b_res);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold control state and the configured prime
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      valid_q       <= 1'b0;
      first_prime_q <= tpds_pkg::FIRST_PRIME_RST;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        first_prime_q <= cfg_wdata_i;
      end
    end
  end

  // Capture the item operands and the result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_q      <= item_i.coord_b;
      q_mod_q  <= q_mod;
      a_zero_q <= (item_i.coord_a == '0);
      b_zero_q <= (item_i.coord_b == '0);
    end
    a_res_q  <= a_res_d;
    result_q <= result_d;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

`ifndef SYNTH
  a_oor_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.out_of_range |->
      !result_o.is_member && !result_o.a_is_residue && !result_o.b_is_residue)
    else $error("out-of-range result carries residue or member flags");

  a_both_res_member: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.a_is_residue && result_o.b_is_residue |->
      result_o.is_member)
    else $error("pair of residues not reported as member");

  a_done_in_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    jac_rsp.done |-> (state_q == S_JAC_A) || (state_q == S_JAC_B))
    else $error("jacobi unit finished outside an evaluation");

  a_result_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_JAC_B) && jac_rsp.done |=> result_valid_o && !busy)
    else $error("finished evaluation did not produce a result");
`endif

endmodule
